// ----- hdl/sist_pkg.sv -----
// sist_pkg: shared constants and types for the symbol intern table
// no dependencies
package sist_pkg;

	localparam int CAPACITY = 256;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CFG_W = 9;
	localparam int ID_W = 9;
	localparam int HASH_W = 64;
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int WORD_W = HASH_W + CNT_W;

	localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF29CE484222325;
	// prime is 2^40 + 0x1b3
	localparam int FNV_PRIME_SHIFT = 40;
	localparam logic [8:0] FNV_PRIME_LO = 9'h1B3;
	localparam logic [CFG_W-1:0] LIMIT_RESET = 9'd256;

	typedef struct packed {
		logic step;
		logic restart;
		logic [7:0] data;
	} fnv_req_t;

endpackage

// ----- hdl/sist_ram.sv -----
// sist_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module sist_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 73,
	parameter int AW = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/sist_fnv.sv -----
// sist_fnv: running fnv-1 style 64-bit hash (byte sign-extended before the xor) with a registered partial product
// depends on sist_pkg
module sist_fnv (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sist_pkg::fnv_req_t            req,
	output logic                          ready,
	output logic [sist_pkg::HASH_W-1:0]   fold
);

	logic [sist_pkg::HASH_W-1:0] hash_q;
	logic [sist_pkg::HASH_W-1:0] prod_q;
	logic                        prod_ok_q;
	logic [sist_pkg::HASH_W-1:0] shifted;
	logic [sist_pkg::HASH_W-1:0] sext;

	assign shifted = {hash_q[sist_pkg::HASH_W-sist_pkg::FNV_PRIME_SHIFT-1:0],
		{sist_pkg::FNV_PRIME_SHIFT{1'b0}}};
	assign sext = {{(sist_pkg::HASH_W-8){req.data[7]}}, req.data};
	assign fold = (shifted + prod_q) ^ sext;
	assign ready = prod_ok_q;

	// low part of the prime product, registered from the current hash
	always_ff @(posedge clk) begin
		prod_q <= sist_pkg::HASH_W'(hash_q * sist_pkg::FNV_PRIME_LO);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= sist_pkg::FNV_BASIS;
			prod_ok_q <= 1'b0;
		end else if (req.step) begin
			hash_q <= req.restart ? sist_pkg::FNV_BASIS : fold;
			prod_ok_q <= 1'b0;
		end else begin
			prod_ok_q <= 1'b1;
		end
	end

endmodule

// ----- hdl/symbol_intern_sorted_hash_table.sv -----
// symbol_intern_sorted_hash_table: top level, sequencer for search and insert
// depends on sist_pkg, sist_fnv, sist_ram
//
// Takes a symbol name one byte per item and folds each byte into a 64-bit
// FNV-1 style hash, with the byte sign-extended before the xor; after each
// byte the next is held off until the registered partial product of the hash
// multiplier is refreshed. On the last byte the hash is looked up by binary
// search in a table sorted by hash, held in one ram with a registered read
// port: a table of n entries needs at most ceil(log2(n)) + 1 probes, each a
// ram read and a compare. A miss then checks the limit; an insert moves every
// later entry up one slot, one read and one write per moved entry, and then
// writes the new entry. A pending result sits in an output register, and
// further non-last bytes are taken meanwhile. No clearing pass is needed
// after reset.
module symbol_intern_sorted_hash_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [sist_pkg::CFG_W-1:0]  table_limit,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  name_byte,
	input  logic                        last_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sist_pkg::ID_W-1:0]   symbol_id,
	output logic [sist_pkg::HASH_W-1:0] symbol_hash,
	output logic                        was_new,
	output logic                        table_full
);

	localparam int CNT_W = sist_pkg::CNT_W;
	localparam int IDX_W = sist_pkg::IDX_W;
	localparam int HASH_W = sist_pkg::HASH_W;
	localparam int CMP_W = sist_pkg::CMP_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SRD,
		ST_SCMP,
		ST_PLACE,
		ST_SHR,
		ST_SHW,
		ST_RES
	} state_t;

	state_t                     state_q;
	logic [sist_pkg::CFG_W-1:0] limit_q;
	logic [CNT_W-1:0]           count_q;
	logic [CNT_W-1:0]           lo_q;
	logic [CNT_W-1:0]           hi_q;
	logic [CNT_W-1:0]           mid_q;
	logic [CNT_W-1:0]           pos_q;
	logic [CNT_W-1:0]           i_q;
	logic [HASH_W-1:0]          h_q;
	logic [CNT_W-1:0]           res_id_q;
	logic                       res_new_q;
	logic                       res_full_q;
	logic                       out_valid_q;
	logic [sist_pkg::ID_W-1:0]  out_id_q;
	logic [HASH_W-1:0]          out_hash_q;
	logic                       out_new_q;
	logic                       out_full_q;

	sist_pkg::fnv_req_t         fnv_req;
	logic                       fnv_ready;
	logic [HASH_W-1:0]          fnv_fold;

	logic                       ram_we;
	logic [IDX_W-1:0]           ram_waddr;
	logic [sist_pkg::WORD_W-1:0] ram_wdata;
	logic [IDX_W-1:0]           ram_raddr;
	logic [sist_pkg::WORD_W-1:0] ram_rdata;
	logic [HASH_W-1:0]          r_hash;
	logic [CNT_W-1:0]           r_id;

	logic                       in_fire;
	logic [CNT_W-1:0]           im1;
	logic [CNT_W-1:0]           cnt_p1;
	logic [CNT_W-1:0]           nlo;
	logic [CNT_W-1:0]           nhi;
	logic [CNT_W-1:0]           nmid;
	logic [CMP_W-1:0]           eff_limit;
	logic                       is_full;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE) && fnv_ready;
	assign in_fire = in_valid && in_ready;

	assign fnv_req.step = in_fire;
	assign fnv_req.restart = last_byte;
	assign fnv_req.data = name_byte;

	sist_fnv u_fnv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fnv_req),
		.ready  (fnv_ready),
		.fold   (fnv_fold)
	);

	assign r_hash = ram_rdata[sist_pkg::WORD_W-1:CNT_W];
	assign r_id = ram_rdata[CNT_W-1:0];
	assign im1 = i_q - 1'b1;
	assign cnt_p1 = count_q + 1'b1;

	// binary search step
	always_comb begin
		if (r_hash > h_q) begin
			nlo = lo_q;
			nhi = mid_q;
		end else begin
			nlo = mid_q;
			nhi = hi_q;
		end
		nmid = nlo + ((nhi - nlo) >> 1);
	end

	assign eff_limit = (CMP_W'(limit_q) > CMP_W'(sist_pkg::CAPACITY)) ?
		CMP_W'(sist_pkg::CAPACITY) : CMP_W'(limit_q);
	assign is_full = CMP_W'(count_q) >= eff_limit;

	always_comb begin
		ram_raddr = mid_q[IDX_W-1:0];
		ram_we = 1'b0;
		ram_waddr = i_q[IDX_W-1:0];
		ram_wdata = ram_rdata;
		case (state_q)
			ST_SHR: begin
				ram_raddr = im1[IDX_W-1:0];
				if (i_q <= pos_q) begin
					ram_we = 1'b1;
					ram_waddr = pos_q[IDX_W-1:0];
					ram_wdata = {h_q, cnt_p1};
				end
			end
			ST_SHW: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_raddr = mid_q[IDX_W-1:0];
			end
		endcase
	end

	sist_ram #(
		.DEPTH (sist_pkg::CAPACITY),
		.WIDTH (sist_pkg::WORD_W),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= sist_pkg::LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= table_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_RES) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire && last_byte) begin
						h_q <= fnv_fold;
						lo_q <= '0;
						hi_q <= count_q;
						mid_q <= count_q >> 1;
						pos_q <= '0;
						state_q <= (count_q == '0) ? ST_PLACE : ST_SRD;
					end
				end
				ST_SRD: begin
					state_q <= ST_SCMP;
				end
				ST_SCMP: begin
					if (r_hash == h_q) begin
						res_id_q <= r_id;
						res_new_q <= 1'b0;
						res_full_q <= 1'b0;
						state_q <= ST_RES;
					end else if (mid_q == lo_q) begin
						pos_q <= (h_q > r_hash) ? mid_q + 1'b1 : mid_q;
						state_q <= ST_PLACE;
					end else begin
						lo_q <= nlo;
						hi_q <= nhi;
						mid_q <= nmid;
						state_q <= ST_SRD;
					end
				end
				ST_PLACE: begin
					if (is_full) begin
						res_id_q <= '0;
						res_new_q <= 1'b0;
						res_full_q <= 1'b1;
						state_q <= ST_RES;
					end else begin
						i_q <= count_q;
						state_q <= ST_SHR;
					end
				end
				ST_SHR: begin
					if (i_q > pos_q) begin
						state_q <= ST_SHW;
					end else begin
						count_q <= cnt_p1;
						res_id_q <= cnt_p1;
						res_new_q <= 1'b1;
						res_full_q <= 1'b0;
						state_q <= ST_RES;
					end
				end
				ST_SHW: begin
					i_q <= im1;
					state_q <= ST_SHR;
				end
				ST_RES: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_id_q <= sist_pkg::ID_W'(res_id_q);
						out_hash_q <= h_q;
						out_new_q <= res_new_q;
						out_full_q <= res_full_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign symbol_id = out_id_q;
	assign symbol_hash = out_hash_q;
	assign was_new = out_new_q;
	assign table_full = out_full_q;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(count_q) <= CNT_W'(sist_pkg::CAPACITY))
		else $error("entry count beyond capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHR && i_q <= pos_q) |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not advance entry count");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && table_full) |-> (!was_new && symbol_id == '0))
		else $error("full result carries an id or new flag");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("item taken during search or insert");

endmodule
